[rtl/core/vrp_pkg.sv]
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types and constants of the video register port.
// ----------------------------------------------------------------------------
package vrp_pkg;

   localparam int PATTERN_BYTES = 8192;
   localparam int PATTERN_AW    = 13;
   localparam int SPRITE_AW     = 8;
   localparam int PALETTE_BYTES = 32;
   localparam int PALETTE_AW    = 5;
   localparam int ADDR_W        = 15;

   localparam logic ACCESS_READ  = 1'b0;
   localparam logic ACCESS_WRITE = 1'b1;

   localparam logic [2:0] REG_CTRL        = 3'd0;
   localparam logic [2:0] REG_MASK        = 3'd1;
   localparam logic [2:0] REG_STATUS      = 3'd2;
   localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
   localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL      = 3'd5;
   localparam logic [2:0] REG_ADDR        = 3'd6;
   localparam logic [2:0] REG_DATA        = 3'd7;

   localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
   localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
   localparam logic [1:0] MIRROR_SINGLE     = 2'd2;
   localparam logic [1:0] MIRROR_FOUR       = 2'd3;

   localparam logic [13:0] NAMETABLE_BASE = 14'h2000;
   localparam logic [13:0] PALETTE_BASE   = 14'h3F00;

   typedef struct packed {
      logic                  accept;
      logic                  clear_en;
      logic [PATTERN_AW-1:0] clear_index;
   } vrp_cmd_type;

endpackage

[rtl/core/vrp_if.sv]
// ----------------------------------------------------------------------------
// vrp_req_if / vrp_rsp_if
// Valid/ready channels for bus accesses and their results.
// ----------------------------------------------------------------------------
interface vrp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [2:0] reg_index;
   logic [7:0] write_data;

   modport source (output valid, req_type, reg_index, write_data, input ready);
   modport sink   (input valid, req_type, reg_index, write_data, output ready);
endinterface

interface vrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [14:0] vram_address;
   logic [14:0] temp_address;
   logic [2:0]  fine_scroll_x;
   logic        latch_first;

   modport source (output valid, read_data, vram_address, temp_address, fine_scroll_x,
                   latch_first, input ready);
   modport sink   (input valid, read_data, vram_address, temp_address, fine_scroll_x,
                   latch_first, output ready);
endinterface

[rtl/core/vrp_ctrl.sv]
// ----------------------------------------------------------------------------
// vrp_ctrl
// Controller: memory clearing sweep after reset, handshake and result slot.
// ----------------------------------------------------------------------------
module vrp_ctrl import vrp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output vrp_cmd_type cmd
);

   localparam logic ST_CLEAR = 1'b0;
   localparam logic ST_RUN   = 1'b1;

   logic                  state_ff, state_in;
   logic [PATTERN_AW-1:0] clear_count_ff, clear_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   assign req_ready = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.accept      = accept;
   assign cmd.clear_en    = (state_ff == ST_CLEAR);
   assign cmd.clear_index = clear_count_ff;

   always_comb begin
      state_in       = state_ff;
      clear_count_in = clear_count_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_count_in = clear_count_ff + 1'b1;
            if (clear_count_ff == PATTERN_AW'(PATTERN_BYTES - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            clear_count_in = clear_count_ff;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_count_ff <= clear_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("transaction accepted during clearing sweep");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result raised without an accepted transaction");

   a_accept_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

endmodule

[rtl/core/vrp_datapath.sv]
// ----------------------------------------------------------------------------
// vrp_datapath
// Register stores, scroll/address latch, address decode and video memories.
// ----------------------------------------------------------------------------
module vrp_datapath import vrp_pkg::*; #(
   parameter int NAMETABLE_BYTES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  vrp_cmd_type         cmd,
   input  logic                req_type,
   input  logic [2:0]          reg_index,
   input  logic [7:0]          write_data,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_write_data,
   output logic [7:0]          read_data,
   output logic [ADDR_W-1:0]   vram_address,
   output logic [ADDR_W-1:0]   temp_address,
   output logic [2:0]          fine_scroll_x,
   output logic                latch_first
);

   localparam int          NT_AW   = $clog2(NAMETABLE_BYTES);
   localparam logic [12:0] NT_SIZE = 13'(NAMETABLE_BYTES);

   logic [7:0]           control_ff, control_in;
   logic [7:0]           mask_ff, mask_in;
   logic [7:0]           status_ff, status_in;
   logic [ADDR_W-1:0]    current_ff, current_in;
   logic [ADDR_W-1:0]    scratch_ff, scratch_in;
   logic [2:0]           fine_x_ff, fine_x_in;
   logic                 first_ff, first_in;
   logic [SPRITE_AW-1:0] sprite_addr_ff, sprite_addr_in;
   logic [1:0]           mirror_ff;
   logic [7:0]           read_data_ff, read_data_in;

   logic [7:0] sprite_mem  [2**SPRITE_AW];
   logic [7:0] pattern_mem [PATTERN_BYTES];
   logic [7:0] nametable_mem [NAMETABLE_BYTES];
   logic [7:0] palette_mem [PALETTE_BYTES];

   logic                  is_write;
   logic                  data_wr;
   logic [13:0]           vaddr;
   logic [1:0]            logical_nt;
   logic [1:0]            phys_nt;
   logic [11:0]           nt_full;
   logic [12:0]           nt_wrap;
   logic [PALETTE_AW-1:0] pal_index;
   logic                  pattern_we, nametable_we, palette_we, sprite_we;

   assign is_write = cmd.accept && (req_type == ACCESS_WRITE);
   assign data_wr  = is_write && (reg_index == REG_DATA);
   assign vaddr    = current_ff[13:0];

   always_comb begin
      logical_nt = vaddr[11:10];
      unique case (mirror_ff)
         MIRROR_VERTICAL:   phys_nt = {1'b0, logical_nt[0]};
         MIRROR_HORIZONTAL: phys_nt = {1'b0, logical_nt[1]};
         MIRROR_SINGLE:     phys_nt = 2'd0;
         MIRROR_FOUR:       phys_nt = logical_nt;
         default:           phys_nt = logical_nt;
      endcase
      nt_full = {phys_nt, vaddr[9:0]};
      if ({1'b0, nt_full} >= NT_SIZE) begin
         nt_wrap = {1'b0, nt_full} - NT_SIZE;
      end else begin
         nt_wrap = {1'b0, nt_full};
      end
      pal_index = vaddr[PALETTE_AW-1:0];
      if (pal_index[4] && (pal_index[1:0] == 2'b00)) begin
         pal_index[4] = 1'b0;
      end
   end

   assign pattern_we   = data_wr && (vaddr < NAMETABLE_BASE);
   assign nametable_we = data_wr && (vaddr >= NAMETABLE_BASE) && (vaddr < PALETTE_BASE);
   assign palette_we   = data_wr && (vaddr >= PALETTE_BASE);
   assign sprite_we    = is_write && (reg_index == REG_SPRITE_DATA);

   always_comb begin
      control_in     = control_ff;
      mask_in        = mask_ff;
      status_in      = status_ff;
      current_in     = current_ff;
      scratch_in     = scratch_ff;
      fine_x_in      = fine_x_ff;
      first_in       = first_ff;
      sprite_addr_in = sprite_addr_ff;
      read_data_in   = 8'd0;
      if (cmd.accept) begin
         if (req_type == ACCESS_READ) begin
            if (reg_index == REG_STATUS) begin
               read_data_in = status_ff;
               first_in     = 1'b1;
            end
         end else begin
            unique case (reg_index)
               REG_CTRL: begin
                  control_in        = write_data;
                  scratch_in[11:10] = write_data[1:0];
               end
               REG_MASK: begin
                  mask_in = write_data;
               end
               REG_STATUS: begin
                  status_in = write_data;
               end
               REG_SPRITE_ADDR: begin
                  sprite_addr_in = write_data;
               end
               REG_SPRITE_DATA: begin
                  sprite_addr_in = sprite_addr_ff + 1'b1;
               end
               REG_SCROLL: begin
                  if (first_ff) begin
                     scratch_in[4:0] = write_data[7:3];
                     fine_x_in       = write_data[2:0];
                  end else begin
                     scratch_in[14:12] = write_data[2:0];
                     scratch_in[9:5]   = write_data[7:3];
                  end
                  first_in = !first_ff;
               end
               REG_ADDR: begin
                  if (first_ff) begin
                     scratch_in[13:8] = write_data[5:0];
                     scratch_in[14]   = 1'b0;
                  end else begin
                     scratch_in[7:0] = write_data;
                     current_in      = {scratch_ff[14:8], write_data};
                  end
                  first_in = !first_ff;
               end
               REG_DATA: begin
                  current_in = current_ff + (control_ff[2] ? ADDR_W'(32) : ADDR_W'(1));
               end
               default: begin
                  current_in = current_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff     <= '0;
         mask_ff        <= '0;
         status_ff      <= '0;
         current_ff     <= '0;
         scratch_ff     <= '0;
         fine_x_ff      <= '0;
         first_ff       <= 1'b1;
         sprite_addr_ff <= '0;
         mirror_ff      <= MIRROR_VERTICAL;
      end else begin
         control_ff     <= control_in;
         mask_ff        <= mask_in;
         status_ff      <= status_in;
         current_ff     <= current_in;
         scratch_ff     <= scratch_in;
         fine_x_ff      <= fine_x_in;
         first_ff       <= first_in;
         sprite_addr_ff <= sprite_addr_in;
         if (csr_write_enable) begin
            mirror_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         read_data_ff <= read_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         pattern_mem[cmd.clear_index] <= 8'd0;
      end else if (pattern_we) begin
         pattern_mem[vaddr[PATTERN_AW-1:0]] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         if (cmd.clear_index < NT_SIZE) begin
            nametable_mem[cmd.clear_index[NT_AW-1:0]] <= 8'd0;
         end
      end else if (nametable_we) begin
         nametable_mem[nt_wrap[NT_AW-1:0]] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         palette_mem[cmd.clear_index[PALETTE_AW-1:0]] <= 8'd0;
      end else if (palette_we) begin
         palette_mem[pal_index] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         sprite_mem[cmd.clear_index[SPRITE_AW-1:0]] <= 8'd0;
      end else if (sprite_we) begin
         sprite_mem[sprite_addr_ff] <= write_data;
      end
   end

   assign read_data     = read_data_ff;
   assign vram_address  = current_ff;
   assign temp_address  = scratch_ff;
   assign fine_scroll_x = fine_x_ff;
   assign latch_first   = first_ff;

   a_status_read_resets_latch: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_type == ACCESS_READ && reg_index == REG_STATUS) |=> first_ff)
      else $error("status read left the write latch set");

   a_addr_second_copies: assert property (@(posedge clock) disable iff (reset)
      (is_write && reg_index == REG_ADDR && !first_ff) |=> (current_ff == scratch_ff))
      else $error("second address write did not load the current address");

   a_idle_holds_addr: assert property (@(posedge clock) disable iff (reset)
      !cmd.accept |=> $stable(current_ff) && $stable(scratch_ff) && $stable(first_ff))
      else $error("address state moved without a transaction");

endmodule

[rtl/core/video_register_port.sv]
// ----------------------------------------------------------------------------
// video_register_port
// CPU-side register port of a tile video unit.
//
//   channel  direction  handshake     payload
//   req_bus  in         valid/ready   req_type, reg_index, write_data
//   rsp_bus  out        valid/ready   read_data, vram_address, temp_address,
//                                     fine_scroll_x, latch_first
//   csr_*    in         write enable  mirroring mode (2 bits)
//
// Each transaction's result is registered; a new transaction is taken every cycle
// while the result register is free or being drained in the same cycle.
// After reset a sweep zeroes the video memories, one entry per cycle, and no
// transaction is taken until it ends; csr writes still land.
// A stalled result holds the input side once the single result slot is full.
// ----------------------------------------------------------------------------
module video_register_port import vrp_pkg::*; #(
   parameter int NAMETABLE_BYTES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   vrp_req_if.sink    req_bus,
   vrp_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   vrp_cmd_type cmd;

   vrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   vrp_datapath #(
      .NAMETABLE_BYTES (NAMETABLE_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_bus.req_type),
      .reg_index        (req_bus.reg_index),
      .write_data       (req_bus.write_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .read_data        (rsp_bus.read_data),
      .vram_address     (rsp_bus.vram_address),
      .temp_address     (rsp_bus.temp_address),
      .fine_scroll_x    (rsp_bus.fine_scroll_x),
      .latch_first      (rsp_bus.latch_first)
   );

endmodule

[test/video_register_port_checker.sv]
// ----------------------------------------------------------------------------
// video_register_port_checker
// Watches the access and result channels of the video register port. It
// keeps its own copy of the port state and mirroring mode, works out the
// result of every accepted access, and compares each result that the block
// hands out with the oldest one still owed. Mismatches and results that
// nobody asked for are counted and handed to the test top.
// ----------------------------------------------------------------------------
module video_register_port_checker import vrp_pkg::*; #(
   parameter int NAMETABLE_BYTES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   vrp_req_if         req_bus,
   vrp_rsp_if         rsp_bus,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   output int         mismatch_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [14:0] vram_address;
      logic [14:0] temp_address;
      logic [2:0]  fine_scroll_x;
      logic        latch_first;
   } port_view_type;

   port_view_type owed_views[$];

   logic [7:0]  ctrl_byte;
   logic [7:0]  mask_byte;
   logic [7:0]  status_byte;
   logic [14:0] vram_addr;
   logic [14:0] temp_addr;
   logic [2:0]  fine_x;
   logic        first_flag;
   logic [7:0]  sprite_ptr;
   logic [1:0]  mirror_sel;

   logic [7:0] sprite_store    [2**SPRITE_AW];
   logic [7:0] pattern_store   [PATTERN_BYTES];
   logic [7:0] nametable_store [NAMETABLE_BYTES];
   logic [7:0] palette_store   [PALETTE_BYTES];

   function automatic port_view_type apply_access(input logic kind, input logic [2:0] idx,
                                                  input logic [7:0] data);
      port_view_type view;
      logic [13:0]   location;
      logic [1:0]    bank;
      logic [4:0]    slot;
      int            nt_index;
      view.read_data = '0;
      if (kind == ACCESS_READ) begin
         if (idx == REG_STATUS) begin
            view.read_data = status_byte;
            first_flag     = 1'b1;
         end
      end else begin
         case (idx)
            REG_CTRL: begin
               ctrl_byte         = data;
               temp_addr[11:10]  = data[1:0];
            end
            REG_MASK:        mask_byte   = data;
            REG_STATUS:      status_byte = data;
            REG_SPRITE_ADDR: sprite_ptr  = data;
            REG_SPRITE_DATA: begin
               sprite_store[sprite_ptr] = data;
               sprite_ptr               = sprite_ptr + 8'd1;
            end
            REG_SCROLL: begin
               if (first_flag) begin
                  temp_addr[4:0] = data[7:3];
                  fine_x         = data[2:0];
               end else begin
                  temp_addr[14:12] = data[2:0];
                  temp_addr[9:5]   = data[7:3];
               end
               first_flag = !first_flag;
            end
            REG_ADDR: begin
               if (first_flag) begin
                  temp_addr[13:8] = data[5:0];
                  temp_addr[14]   = 1'b0;
               end else begin
                  temp_addr[7:0] = data;
                  vram_addr      = temp_addr;
               end
               first_flag = !first_flag;
            end
            default: begin
               location = vram_addr[13:0];
               if (location < NAMETABLE_BASE) begin
                  pattern_store[location[PATTERN_AW-1:0]] = data;
               end else if (location < PALETTE_BASE) begin
                  case (mirror_sel)
                     MIRROR_VERTICAL:   bank = {1'b0, location[10]};
                     MIRROR_HORIZONTAL: bank = {1'b0, location[11]};
                     MIRROR_SINGLE:     bank = 2'd0;
                     default:           bank = location[11:10];
                  endcase
                  nt_index = (int'(bank) * 1024 + int'(location[9:0])) % NAMETABLE_BYTES;
                  nametable_store[nt_index] = data;
               end else begin
                  slot = location[4:0];
                  if (slot[4] && slot[1:0] == 2'd0)
                     slot[4] = 1'b0;
                  palette_store[slot] = data;
               end
               vram_addr = vram_addr + (ctrl_byte[2] ? 15'd32 : 15'd1);
            end
         endcase
      end
      view.vram_address  = vram_addr;
      view.temp_address  = temp_addr;
      view.fine_scroll_x = fine_x;
      view.latch_first   = first_flag;
      return view;
   endfunction

   always @(posedge clock) begin : watch
      port_view_type want;
      port_view_type got;
      int            errors;
      errors = mismatch_count;
      if (reset) begin
         ctrl_byte   = '0;
         mask_byte   = '0;
         status_byte = '0;
         vram_addr   = '0;
         temp_addr   = '0;
         fine_x      = '0;
         first_flag  = 1'b1;
         sprite_ptr  = '0;
         mirror_sel  = MIRROR_VERTICAL;
         foreach (sprite_store[k])    sprite_store[k]    = '0;
         foreach (pattern_store[k])   pattern_store[k]   = '0;
         foreach (nametable_store[k]) nametable_store[k] = '0;
         foreach (palette_store[k])   palette_store[k]   = '0;
         owed_views.delete();
         errors = 0;
      end else begin
         if (csr_write_enable)
            mirror_sel = csr_write_data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.read_data, rsp_bus.vram_address, rsp_bus.temp_address,
                   rsp_bus.fine_scroll_x, rsp_bus.latch_first};
            if (owed_views.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result with no access waiting: rd=%h va=%h ta=%h fx=%0d lf=%b",
                           $realtime, got.read_data, got.vram_address, got.temp_address,
                           got.fine_scroll_x, got.latch_first);
            end else begin
               want = owed_views.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected rd=%h va=%h ta=%h fx=%0d lf=%b", want.read_data,
                              want.vram_address, want.temp_address, want.fine_scroll_x,
                              want.latch_first);
                     $display("   actual   rd=%h va=%h ta=%h fx=%0d lf=%b", got.read_data,
                              got.vram_address, got.temp_address, got.fine_scroll_x,
                              got.latch_first);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            owed_views.push_back(apply_access(req_bus.req_type, req_bus.reg_index,
                                              req_bus.write_data));
      end
      mismatch_count <= errors;
      pending_count  <= owed_views.size();
   end

endmodule

[test/video_register_port_test.sv]
// ----------------------------------------------------------------------------
// video_register_port_test
// Drives bus accesses into the video register port: a directed pass over
// every register, the data extremes and the wrap and mirror cases, then
// random access sequences shaped like real register setup under each
// nametable mirroring mode. Both channels idle at random; the result side
// also holds off once for a long stretch. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module video_register_port_test import vrp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NT_BYTES       = 4096;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 106;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_write_data;
   int         mismatch_count;
   int         pending_count;
   int         accesses_sent;
   int         idle_cycles;
   bit         no_idle;
   bit         long_hold_due;

   vrp_req_if req_bus();
   vrp_rsp_if rsp_bus();

   video_register_port #(
      .NAMETABLE_BYTES(NT_BYTES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   video_register_port_checker #(
      .NAMETABLE_BYTES(NT_BYTES)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic drive_access(input logic kind, input logic [2:0] idx, input logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.req_type   = kind;
      req_bus.reg_index  = idx;
      req_bus.write_data = data;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      accesses_sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
      drive_access(ACCESS_WRITE, idx, data);
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   task automatic set_mirroring(input logic [1:0] mode);
      csr_write_enable = 1'b1;
      csr_write_data   = mode;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic random_sequence();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            drive_access(ACCESS_READ, REG_STATUS, 8'($urandom_range(0, 255)));
            write_reg(REG_ADDR, 8'($urandom_range(0, 255)));
            write_reg(REG_ADDR, 8'($urandom_range(0, 255)));
            n = $urandom_range(1, 6);
            repeat (n) write_reg(REG_DATA, 8'($urandom_range(0, 255)));
         end
         3, 4: begin
            drive_access(ACCESS_READ, REG_STATUS, 8'($urandom_range(0, 255)));
            write_reg(REG_SCROLL, 8'($urandom_range(0, 255)));
            write_reg(REG_SCROLL, 8'($urandom_range(0, 255)));
         end
         5: begin
            write_reg(REG_CTRL, 8'($urandom_range(0, 255)));
            write_reg(REG_SPRITE_ADDR, 8'($urandom_range(0, 255)));
            n = $urandom_range(1, 4);
            repeat (n) write_reg(REG_SPRITE_DATA, 8'($urandom_range(0, 255)));
         end
         6: begin
            write_reg(REG_MASK, 8'($urandom_range(0, 255)));
            write_reg(REG_STATUS, 8'($urandom_range(0, 255)));
            drive_access(ACCESS_READ, REG_STATUS, 8'($urandom_range(0, 255)));
         end
         default: begin
            n = $urandom_range(1, 4);
            repeat (n) drive_access(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                    8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   // result side: random ready with one long hold-off on request
   initial begin
      int r;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_bus.ready = 1'b1;
            repeat ($urandom_range(0, 19)) @(negedge clock);
         end else if (r < 70) begin
            rsp_bus.ready = 1'b1;
            repeat ($urandom_range(50, 150)) @(negedge clock);
         end else if (r < 95) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [1:0] mirror_plan [5];
      int         target;
      mirror_plan = '{MIRROR_FOUR, MIRROR_VERTICAL, MIRROR_HORIZONTAL, MIRROR_SINGLE,
                      MIRROR_VERTICAL};
      mirror_plan[4]     = 2'($urandom_range(0, 3));
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = ACCESS_READ;
      req_bus.reg_index  = REG_CTRL;
      req_bus.write_data = '0;
      accesses_sent      = 0;
      no_idle            = 1'b0;
      long_hold_due      = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      set_mirroring(MIRROR_SINGLE);
      write_reg(REG_STATUS, 8'hFF);
      for (int i = 0; i < 8; i++)
         drive_access(ACCESS_READ, i[2:0], 8'hFF);
      write_reg(REG_CTRL, 8'hFF);
      write_reg(REG_MASK, 8'hFF);
      write_reg(REG_SPRITE_ADDR, 8'hFF);
      write_reg(REG_SPRITE_DATA, 8'hA5);
      write_reg(REG_SPRITE_DATA, 8'h5A);
      // build 0x7FFF through the shared latch, then wrap by 32
      write_reg(REG_ADDR, 8'hFF);
      write_reg(REG_SCROLL, 8'hFF);
      write_reg(REG_SCROLL, 8'hFF);
      write_reg(REG_ADDR, 8'hFF);
      write_reg(REG_DATA, 8'h00);
      write_reg(REG_CTRL, 8'h00);
      write_reg(REG_ADDR, 8'h3F);
      write_reg(REG_ADDR, 8'h10);
      write_reg(REG_DATA, 8'h11);
      write_reg(REG_ADDR, 8'h24);
      write_reg(REG_ADDR, 8'h00);
      write_reg(REG_DATA, 8'hFF);

      for (int p = 0; p < 5; p++) begin
         drain_results();
         set_mirroring(mirror_plan[p]);
         if (p == 2)
            long_hold_due = 1'b1;
         target = accesses_sent + PHASE_ITEMS;
         while (accesses_sent < target) begin
            no_idle = ($urandom_range(0, 3) == 0);
            random_sequence();
         end
      end
      drain_results();
      repeat (20) @(negedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/core/vrp_pkg.sv
rtl/core/vrp_if.sv
rtl/core/vrp_ctrl.sv
rtl/core/vrp_datapath.sv
rtl/core/video_register_port.sv
test/video_register_port_checker.sv
test/video_register_port_test.sv
